// File: rtl/pdaw_pkg.sv
// ----------------------------------------------------------------------------
// pdaw_pkg
// Types and constants for the PID controller with deadband and anti-windup.
// ----------------------------------------------------------------------------
package pdaw_pkg;

    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 32;
    localparam int LIM_W     = 31;
    localparam int FRAC_BITS = 16;
    localparam int CFG_IDX_W = 3;

    localparam int DIFF_W   = DATA_W + 1;
    localparam int PROD_W   = GAIN_W + DATA_W;
    localparam int DPROD_W  = GAIN_W + DIFF_W;
    localparam int TERM_W   = PROD_W - FRAC_BITS;
    localparam int DTERM_W  = DPROD_W - FRAC_BITS;
    localparam int SUM_W    = DTERM_W + 2;

    typedef enum logic
    {
        OP_CALC  = 1'b0,
        OP_RESET = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_KP_GAIN        = 3'd0,
        REG_KI_GAIN        = 3'd1,
        REG_KD_GAIN        = 3'd2,
        REG_OUTPUT_LIMIT   = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_DEAD_BAND      = 3'd5
    } reg_idx_t;

endpackage

// File: rtl/pdaw_if.sv
// ----------------------------------------------------------------------------
// pdaw_if
// Valid/ready channels for requests and results of the PID controller.
// ----------------------------------------------------------------------------
interface pdaw_req_if;
    logic                                valid;
    logic                                ready;
    pdaw_pkg::op_t                       op;
    logic signed [pdaw_pkg::DATA_W-1:0]  error_value;

    modport source (output valid, output op, output error_value, input ready);
    modport sink   (input valid, input op, input error_value, output ready);
endinterface

interface pdaw_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [pdaw_pkg::DATA_W-1:0]  drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

// File: rtl/pid_deadband_antiwindup_unit.sv
// ----------------------------------------------------------------------------
// pid_deadband_antiwindup_unit
// Positional Q16.16 PID controller with deadband, integral clamp and output
// clamp.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the result side keeps up. A
// calculate request returns its drive value through the input register,
// integral/deadband stage (which also updates the controller state, so
// consecutive requests chain without gaps), multiplier stage and
// sum/saturate stage feeding the output register. A reset request clears
// the integral and the previous error and returns nothing. The user must
// write gains and limits through the cfg port only while no request is in
// flight (the block does not enforce this); writes do not touch the state.
module pid_deadband_antiwindup_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [pdaw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdaw_pkg::GAIN_W-1:0]        cfg_data,
    pdaw_req_if.sink                           req,
    pdaw_rsp_if.source                         rsp
);
    import pdaw_pkg::*;

    // configuration
    logic signed [GAIN_W-1:0]  kp_reg, ki_reg, kd_reg;
    logic        [LIM_W-1:0]   olim_reg, ilim_reg, db_reg;

    // controller state
    logic signed [DATA_W-1:0]  prev_reg, integ_reg;
    logic signed [DATA_W-1:0]  prev_next, integ_next;

    // stage 0: input register
    logic                      v0_reg;
    op_t                       op0_reg;
    logic signed [DATA_W-1:0]  e0_reg;

    // stage 1: multiplier operands
    logic                      v1_reg, band1_reg;
    logic signed [DATA_W-1:0]  e1_reg, integ1_reg;
    logic signed [DIFF_W-1:0]  diff1_reg;
    logic                      band1_next;
    logic signed [DATA_W-1:0]  integ1_next;
    logic signed [DIFF_W-1:0]  diff1_next;

    // stage 2: products
    logic                      v2_reg, band2_reg;
    logic signed [PROD_W-1:0]  pprod_reg, iprod_reg;
    logic signed [DPROD_W-1:0] dprod_reg;
    logic signed [PROD_W-1:0]  pprod_next, iprod_next;
    logic signed [DPROD_W-1:0] dprod_next;

    // output register
    logic                      ov_reg;
    logic signed [DATA_W-1:0]  drive_reg, drive_next;

    logic en0, en1, en2, eno, fire0;

    logic signed [DIFF_W-1:0]  e_x, db_x, ilim_x, isum_x, olim_x, sat_x;
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [DATA_W-1:0]  sat_v;

    assign eno = !ov_reg || rsp.ready;
    assign en2 = !v2_reg || eno;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;
    assign fire0 = v0_reg && en1;

    assign req.ready = en0;
    assign rsp.valid = ov_reg;
    assign rsp.drive = drive_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg   <= '0;
            ki_reg   <= '0;
            kd_reg   <= '0;
            olim_reg <= '0;
            ilim_reg <= '0;
            db_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KP_GAIN:        kp_reg   <= cfg_data;
                REG_KI_GAIN:        ki_reg   <= cfg_data;
                REG_KD_GAIN:        kd_reg   <= cfg_data;
                REG_OUTPUT_LIMIT:   olim_reg <= cfg_data[LIM_W-1:0];
                REG_INTEGRAL_LIMIT: ilim_reg <= cfg_data[LIM_W-1:0];
                REG_DEAD_BAND:      db_reg   <= cfg_data[LIM_W-1:0];
                default:            ;
            endcase
        end
    end

    // stage 1 logic: deadband, integral update, error difference
    always_comb
    begin
        e_x    = DIFF_W'(e0_reg);
        db_x   = $signed({2'b00, db_reg});
        ilim_x = $signed({2'b00, ilim_reg});
        isum_x = DIFF_W'(integ_reg) + e_x;

        band1_next = (e_x > -db_x) && (e_x < db_x);
        diff1_next = e_x - DIFF_W'(prev_reg);

        priority if (isum_x > ilim_x)
            integ1_next = ilim_x[DATA_W-1:0];
        else if (isum_x < -ilim_x)
            integ1_next = -ilim_x[DATA_W-1:0];
        else
            integ1_next = isum_x[DATA_W-1:0];

        prev_next  = prev_reg;
        integ_next = integ_reg;
        if (fire0)
        begin
            priority if (op0_reg == OP_RESET)
            begin
                prev_next  = '0;
                integ_next = '0;
            end
            else if (band1_next)
            begin
                prev_next  = e0_reg;
                integ_next = '0;
            end
            else
            begin
                prev_next  = e0_reg;
                integ_next = integ1_next;
            end
        end
    end

    // stage 2 logic: products
    always_comb
    begin
        pprod_next = kp_reg * e1_reg;
        iprod_next = ki_reg * integ1_reg;
        dprod_next = kd_reg * diff1_reg;
    end

    // output logic: floor shift, sum, saturate, clamp
    always_comb
    begin
        sum_x = SUM_W'($signed(pprod_reg[PROD_W-1:FRAC_BITS]))
              + SUM_W'($signed(iprod_reg[PROD_W-1:FRAC_BITS]))
              + SUM_W'($signed(dprod_reg[DPROD_W-1:FRAC_BITS]));

        if (sum_x[SUM_W-1:DATA_W-1] != {(SUM_W-DATA_W+1){sum_x[SUM_W-1]}})
            sat_v = sum_x[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                   : {1'b0, {(DATA_W-1){1'b1}}};
        else
            sat_v = sum_x[DATA_W-1:0];

        sat_x  = DIFF_W'(sat_v);
        olim_x = $signed({2'b00, olim_reg});

        priority if (band2_reg)
            drive_next = '0;
        else if (sat_x > olim_x)
            drive_next = olim_x[DATA_W-1:0];
        else if (sat_x < -olim_x)
            drive_next = -olim_x[DATA_W-1:0];
        else
            drive_next = sat_v;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            prev_reg  <= '0;
            integ_reg <= '0;
        end
        else
        begin
            prev_reg  <= prev_next;
            integ_reg <= integ_next;
            if (en0)
                v0_reg <= req.valid;
            if (en1)
                v1_reg <= v0_reg && (op0_reg == OP_CALC);
            if (en2)
                v2_reg <= v1_reg;
            if (eno)
                ov_reg <= v2_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            op0_reg <= req.op;
            e0_reg  <= req.error_value;
        end
        if (en1)
        begin
            band1_reg  <= band1_next;
            e1_reg     <= e0_reg;
            integ1_reg <= integ1_next;
            diff1_reg  <= diff1_next;
        end
        if (en2)
        begin
            band2_reg <= band1_reg;
            pprod_reg <= pprod_next;
            iprod_reg <= iprod_next;
            dprod_reg <= dprod_next;
        end
        if (eno)
            drive_reg <= drive_next;
    end

endmodule

// File: tb/pid_deadband_antiwindup_unit_test.sv
// ----------------------------------------------------------------------------
// pid_deadband_antiwindup_unit_test
// Self-checking bench for the Q16.16 PID controller. Requests go in through
// the valid/ready request channel in random bursts while the result side
// stalls on its own schedule. A controller model predicts each
// drive value, and every result is compared in order against it. Directed
// tests cover the deadband edges, integral clamp, product saturation and zero
// limits; then randomized gain/limit settings run mixed traffic.
// ----------------------------------------------------------------------------
module pid_deadband_antiwindup_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pdaw_pkg::*;

    localparam int     LATENCY_WAIT = 12;
    localparam longint CYCLE_LIMIT  = 200000;
    localparam int     RANDOM_SETS  = 8;
    localparam int     SET_REQS     = 80;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam logic [31:0] Q_ONE  = 32'h0001_0000;
    localparam logic [31:0] S_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] S_MIN  = 32'h8000_0000;

    localparam longint DRIVE_MAX = 64'sd2147483647;
    localparam longint DRIVE_MIN = -64'sd2147483648;

    typedef enum int
    {
        FLOW_FREE,
        FLOW_LIGHT,
        FLOW_HEAVY,
        FLOW_PERIODIC
    } flow_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [GAIN_W-1:0]     cfg_data  = '0;

    pdaw_req_if req_ch ();
    pdaw_rsp_if rsp_ch ();

    pid_deadband_antiwindup_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // controller model state
    logic signed [31:0] kp_q = '0;
    logic signed [31:0] ki_q = '0;
    logic signed [31:0] kd_q = '0;
    longint             drive_lim = 0;
    longint             integ_lim = 0;
    longint             band_half = 0;
    longint             last_err  = 0;
    longint             integ_acc = 0;

    logic signed [31:0] drive_q[$];
    logic signed [31:0] want_drive;
    int                 mismatches  = 0;
    int                 burst_left  = 0;
    longint             cycle_count = 0;
    flow_t              flow_mode   = FLOW_FREE;
    int                 flow_span   = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic signed [31:0] step_controller(input logic signed [31:0] err);
        longint             e;
        longint             acc;
        longint             p_term;
        longint             i_term;
        longint             d_term;
        longint             total;
        logic signed [79:0] prod;
        e = err;
        if (e > -band_half && e < band_half)
        begin
            last_err  = e;
            integ_acc = 0;
            return '0;
        end
        acc = integ_acc + e;
        if (acc > integ_lim)
            acc = integ_lim;
        else if (acc < -integ_lim)
            acc = -integ_lim;
        integ_acc = acc;
        prod   = kp_q * e;
        p_term = prod[FRAC_BITS+63:FRAC_BITS];
        prod   = ki_q * acc;
        i_term = prod[FRAC_BITS+63:FRAC_BITS];
        prod   = kd_q * (e - last_err);
        d_term = prod[FRAC_BITS+63:FRAC_BITS];
        last_err = e;
        total = p_term + i_term + d_term;
        if (total > DRIVE_MAX)
            total = DRIVE_MAX;
        if (total < DRIVE_MIN)
            total = DRIVE_MIN;
        if (total > drive_lim)
            total = drive_lim;
        else if (total < -drive_lim)
            total = -drive_lim;
        return total[31:0];
    endfunction

    function automatic logic [31:0] rand_signed(input int unsigned mag);
        logic [31:0] v;
        v = $urandom_range(0, mag);
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %0s: expected %h actual %h at cycle %0d",
                     what, want, got, cycle_count);
    endtask

    // result side: the stall pattern is redrawn whenever its span runs out
    always @(posedge clk)
    begin
        if (flow_span == 0)
        begin
            flow_mode = flow_t'($urandom_range(0, 3));
            flow_span = $urandom_range(8, 60);
        end
        flow_span--;
        case (flow_mode)
            FLOW_FREE:  rsp_ch.ready <= 1'b1;
            FLOW_LIGHT: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            FLOW_HEAVY: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default:    rsp_ch.ready <= (flow_span % 3 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (drive_q.size() == 0)
                report_mismatch("unexpected drive", 'x, rsp_ch.drive);
            else
            begin
                want_drive = drive_q.pop_front();
                if (rsp_ch.drive !== want_drive)
                    report_mismatch("drive", want_drive, rsp_ch.drive);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_req(input op_t op, input logic [31:0] err);
        int gap;
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.error_value <= err;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        if (op == OP_CALC)
            drive_q.push_back(step_controller($signed(err)));
        else
        begin
            last_err  = 0;
            integ_acc = 0;
        end
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            if ($urandom_range(0, 7) == 0)
                burst_left = $urandom_range(40, 80);
            else
                burst_left = $urandom_range(1, 12);
        end
    endtask

    task automatic drain_pipeline();
        if (req_ch.valid)
            req_ch.valid <= 1'b0;
        burst_left = 0;
        while (drive_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            REG_KP_GAIN:        kp_q = value;
            REG_KI_GAIN:        ki_q = value;
            REG_KD_GAIN:        kd_q = value;
            REG_OUTPUT_LIMIT:   drive_lim = longint'(value[30:0]);
            REG_INTEGRAL_LIMIT: integ_lim = longint'(value[30:0]);
            REG_DEAD_BAND:      band_half = longint'(value[30:0]);
            default: ;
        endcase
    endtask

    // the spare index must leave every register alone
    task automatic apply_setup(input logic [31:0] kp, input logic [31:0] ki,
                               input logic [31:0] kd, input logic [31:0] out_lim,
                               input logic [31:0] int_lim, input logic [31:0] band);
        write_reg(REG_KP_GAIN, kp);
        write_reg(REG_KI_GAIN, ki);
        write_reg(REG_KD_GAIN, kd);
        write_reg(REG_OUTPUT_LIMIT, out_lim);
        write_reg(REG_INTEGRAL_LIMIT, int_lim);
        write_reg(REG_DEAD_BAND, band);
        write_reg(REG_SPARE, $urandom);
        cfg_write <= 1'b0;
    endtask

    task automatic test_power_on_defaults();
        send_req(OP_CALC, S_MAX);
        send_req(OP_CALC, S_MIN);
        send_req(OP_CALC, 32'h0);
    endtask

    task automatic test_deadband_edges();
        drain_pipeline();
        apply_setup(Q_ONE, 32'h0, 32'h0, S_MAX, S_MAX, 32'h1000);
        send_req(OP_CALC, 32'h0000_0FFF);
        send_req(OP_CALC, 32'h0000_1000);
        send_req(OP_CALC, 32'hFFFF_F001);
        send_req(OP_CALC, 32'hFFFF_F000);
        send_req(OP_CALC, 32'h0);
    endtask

    task automatic test_integral_clamp();
        drain_pipeline();
        apply_setup(32'h0, Q_ONE, 32'h0000_8000, S_MAX, 32'h0003_0000, 32'h0);
        send_req(OP_CALC, 32'h0002_0000);
        send_req(OP_CALC, 32'h0002_0000);
        send_req(OP_CALC, 32'h0002_0000);
        send_req(OP_CALC, 32'h8000_0001);
        send_req(OP_RESET, 32'hDEAD_BEEF);
        send_req(OP_CALC, Q_ONE);
    endtask

    task automatic test_product_saturation();
        drain_pipeline();
        apply_setup(S_MIN, S_MAX, S_MAX, S_MAX, S_MAX, 32'h0);
        send_req(OP_CALC, S_MIN);
        send_req(OP_CALC, S_MAX);
        send_req(OP_CALC, S_MIN);
        send_req(OP_RESET, 32'h0);
        send_req(OP_CALC, S_MAX);
    endtask

    task automatic test_zero_limits();
        drain_pipeline();
        apply_setup(Q_ONE, S_MIN, S_MAX, 32'h0, 32'h0, S_MAX);
        send_req(OP_CALC, S_MIN);
        send_req(OP_CALC, S_MAX);
        send_req(OP_CALC, 32'h0001_2345);
    endtask

    task automatic test_random_traffic();
        logic [31:0] gains[3];
        logic [31:0] lims[3];
        logic [31:0] err;
        longint      pick;
        for (int set = 0; set < RANDOM_SETS; set++)
        begin
            drain_pipeline();
            for (int g = 0; g < 3; g++)
                case ($urandom_range(0, 5))
                    0:       gains[g] = 32'h0;
                    1:       gains[g] = $urandom;
                    default: gains[g] = rand_signed(32'h0004_0000);
                endcase
            for (int l = 0; l < 3; l++)
                case ($urandom_range(0, 7))
                    0:       lims[l] = 32'h0;
                    1:       lims[l] = S_MAX;
                    2:       lims[l] = $urandom_range(0, 32'h7FFF_FFFF);
                    default: lims[l] = $urandom_range(0, 32'h0008_0000);
                endcase
            if ($urandom_range(0, 2) != 0)
                lims[2] = $urandom_range(0, 32'h2000);
            apply_setup(gains[0], gains[1], gains[2], lims[0], lims[1], lims[2]);
            for (int n = 0; n < SET_REQS; n++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_req(OP_RESET, $urandom);
                else
                begin
                    case ($urandom_range(0, 7))
                        0: err = $urandom;
                        1:
                        begin
                            case ($urandom_range(0, 3))
                                0:       pick = band_half;
                                1:       pick = -band_half;
                                2:       pick = band_half - 1;
                                default: pick = 1 - band_half;
                            endcase
                            err = pick[31:0];
                        end
                        2: err = $urandom_range(0, 1) ? S_MAX : S_MIN;
                        default: err = rand_signed(32'h0004_0000);
                    endcase
                    send_req(OP_CALC, err);
                end
            end
        end
    endtask

    initial
    begin
        req_ch.valid       = 1'b0;
        req_ch.op          = OP_CALC;
        req_ch.error_value = '0;
        rsp_ch.ready       = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_defaults();
        test_deadband_edges();
        test_integral_clamp();
        test_product_saturation();
        test_zero_limits();
        test_random_traffic();

        drain_pipeline();
        if (mismatches == 0 && drive_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/pdaw_pkg.sv
rtl/pdaw_if.sv
rtl/pid_deadband_antiwindup_unit.sv
tb/pid_deadband_antiwindup_unit_test.sv
